@@ hdl/bmps_pkg.sv @@
// Shared constants and the CORDIC arctangent table for the bicycle pose stepper.
package bmps_pkg;

    localparam int CW = 36;                       // CORDIC datapath width
    localparam int MW = 35;                       // multiplier operand width
    localparam int PW = 2 * MW;                   // product width
    localparam int DIV_BITS = 91;                 // dividend bits: 47-bit numerator << 44
    localparam int NUM_W = 47;
    localparam int DEN_W = 64;

    localparam logic [29:0] INV_GAIN     = 30'd652032874;
    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
    localparam logic [30:0] TWO_PI_Q28   = 31'd1686629713;
    localparam logic signed [16:0] STEER_MAX = 17'sd16384;

    localparam logic [1:0] REG_FRONT = 2'd0;
    localparam logic [1:0] REG_REAR  = 2'd1;
    localparam logic [1:0] REG_DT    = 2'd2;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0:    r = 30'd536870912;
                5'd1:    r = 30'd316933406;
                5'd2:    r = 30'd167458907;
                5'd3:    r = 30'd85004756;
                5'd4:    r = 30'd42667331;
                5'd5:    r = 30'd21354465;
                5'd6:    r = 30'd10680350;
                5'd7:    r = 30'd5340245;
                5'd8:    r = 30'd2670163;
                5'd9:    r = 30'd1335087;
                5'd10:   r = 30'd667544;
                5'd11:   r = 30'd333772;
                5'd12:   r = 30'd166886;
                5'd13:   r = 30'd83443;
                5'd14:   r = 30'd41722;
                5'd15:   r = 30'd20861;
                5'd16:   r = 30'd10430;
                5'd17:   r = 30'd5215;
                5'd18:   r = 30'd2608;
                5'd19:   r = 30'd1304;
                5'd20:   r = 30'd652;
                5'd21:   r = 30'd326;
                5'd22:   r = 30'd163;
                5'd23:   r = 30'd81;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hdl/bicycle_model_pose_step.sv @@
// Kinematic bicycle model: one Euler pose step per transaction, built on a shared CORDIC.
//
// Usage: each input transaction (speed, steer_angle) on the in_valid/in_ready channel
// advances the stored pose (x, y, heading) by one time step and produces one output
// transaction carrying the new pose on out_valid/out_ready.
// The block works on one item at a time. in_ready is high only while idle.
// The 91-step restoring divider for the heading rate and the three passes of the single
// CORDIC unit are the longest parts of the sequence from acceptance to out_valid.
// When both axle distances are zero the vectoring pass and the divider are skipped;
// a non-positive magnitude skips the divider only.
// One signed 35x35 multiplier is shared by every product in the sequence.
// The result waits in output registers until out_ready; a stalled receiver holds the
// block, and no new input is taken until the result transaction completes.
// Configuration (cfg_we, cfg_index, cfg_data) writes the front axle distance, rear
// axle distance and time step; index 3 is ignored. Write only while idle.
// Reset clears the pose to zero and loads the default configuration.
module bicycle_model_pose_step #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        speed,
    input  logic signed [15:0] steer_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [15:0]        heading,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import bmps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_MD, S_RD, S_ROT1, S_MX, S_MY, S_VINIT, S_VEC, S_MG, S_MS,
        S_MA, S_MDEN, S_DCHK, S_DIV, S_ANG, S_ROT2, S_PX, S_PY, S_UPD, S_OUT
    } state_t;

    localparam int IW = $clog2(CORDIC_STEPS);

    state_t state_reg;
    logic [15:0] lf_reg, lr_reg, dt_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [15:0] ph_reg;
    logic [15:0] v_reg;
    logic signed [16:0] d_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic rot_reg;
    logic [6:0] cnt_reg;
    logic signed [CW-1:0] c_reg, s_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [31:0] beta_reg;
    logic [31:0] r_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DIV_BITS-1:0] dvd_reg;
    logic [31:0] q_reg;
    logic [31:0] dpsi_reg;
    logic flip_reg;
    logic [31:0] vdt_reg;

    // Shared multiplier.
    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] mp;
    assign mp = ma * mb;

    logic [16:0] len_sum;
    assign len_sum = {1'b0, lf_reg} + {1'b0, lr_reg};

    logic signed [CW-1:0] abs_s;
    assign abs_s = s_reg[CW-1] ? -s_reg : s_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_MD:    begin ma = MW'(d_reg); mb = MW'({1'b0, TURN_PER_RAD}); end
            S_MX:    begin ma = MW'({1'b0, len_sum}); mb = MW'(c_reg); end
            S_MY:    begin ma = MW'({1'b0, lr_reg}); mb = MW'(s_reg); end
            S_MG:    begin ma = MW'(cx_reg); mb = MW'({1'b0, INV_GAIN}); end
            S_MS:    begin ma = MW'({1'b0, v_reg}); mb = MW'(abs_s); end
            S_MA:    begin ma = MW'(prod_reg >>> 16); mb = MW'({1'b0, dt_reg}); end
            S_MDEN:  begin ma = MW'({1'b0, r_reg}); mb = MW'({1'b0, TWO_PI_Q28}); end
            S_ANG:   begin ma = MW'({1'b0, v_reg}); mb = MW'({1'b0, dt_reg}); end
            S_PX:    begin ma = MW'({1'b0, prod_reg[31:0]});
                           mb = MW'(flip_reg ? -cx_reg : cx_reg); end
            S_PY:    begin ma = MW'({1'b0, vdt_reg});
                           mb = MW'(flip_reg ? -cy_reg : cy_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // Shared CORDIC micro-rotation.
    logic [4:0] ci;
    logic signed [CW-1:0] xs, ys, at;
    logic pos;
    assign ci  = 5'(cnt_reg[IW-1:0]);
    assign xs  = cx_reg >>> ci;
    assign ys  = cy_reg >>> ci;
    assign at  = CW'({1'b0, atan_turn(ci)});
    assign pos = rot_reg ? ~cz_reg[CW-1] : cy_reg[CW-1];

    logic cordic_last;
    assign cordic_last = (cnt_reg[IW-1:0] == IW'(CORDIC_STEPS - 1));

    // Divider step.
    logic [DEN_W:0] rem_sh;
    assign rem_sh = {rem_reg, dvd_reg[DIV_BITS-1]};

    // Heading plus slip angle, folded into the right half plane.
    logic [31:0] au;
    logic signed [32:0] a_s, a_f;
    logic a_flip;
    always_comb
    begin
        au = {ph_reg, 16'h0} + beta_reg;
        a_s = 33'(signed'(au));
        a_flip = 1'b0;
        a_f = a_s;
        if (a_s > 33'sd1073741824)
        begin
            a_f = a_s - 33'sd2147483648;
            a_flip = 1'b1;
        end
        else if (a_s < -33'sd1073741824)
        begin
            a_f = a_s + 33'sd2147483648;
            a_flip = 1'b1;
        end
    end

    logic signed [PW-1:0] dround;
    logic signed [33:0] sum_x;
    logic signed [31:0] sat_x;
    assign dround = (prod_reg + (PW'(1) <<< 37)) >>> 38;
    assign sum_x = 34'(px_reg) + 34'(dround);
    always_comb
    begin
        sat_x = sum_x[31:0];
        if (sum_x > 34'sd2147483647)
            sat_x = 32'sh7fffffff;
        else if (sum_x < -34'sd2147483648)
            sat_x = 32'sh80000000;
    end
    logic signed [33:0] sum_y;
    logic signed [31:0] sat_y;
    assign sum_y = 34'(py_reg) + 34'(dround);
    always_comb
    begin
        sat_y = sum_y[31:0];
        if (sum_y > 34'sd2147483647)
            sat_y = 32'sh7fffffff;
        else if (sum_y < -34'sd2147483648)
            sat_y = 32'sh80000000;
    end

    logic [31:0] hd;
    assign hd = {ph_reg, 16'h0} + dpsi_reg + 32'h8000;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign heading   = ph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lf_reg <= 16'd307;
            lr_reg <= 16'd307;
            dt_reg <= 16'd6554;
            px_reg <= '0;
            py_reg <= '0;
            ph_reg <= '0;
            cnt_reg <= '0;
            rot_reg <= 1'b1;
            flip_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRONT: lf_reg <= cfg_data;
                    REG_REAR:  lr_reg <= cfg_data;
                    REG_DT:    dt_reg <= cfg_data;
                    default:   ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        v_reg <= speed;
                        if (17'(steer_angle) > STEER_MAX)
                            d_reg <= STEER_MAX;
                        else if (17'(steer_angle) < -STEER_MAX)
                            d_reg <= -STEER_MAX;
                        else
                            d_reg <= 17'(steer_angle);
                        state_reg <= S_MD;
                    end
                end
                S_MD:
                begin
                    prod_reg <= mp;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    cz_reg <= CW'((prod_reg + (PW'(1) <<< 13)) >>> 14);
                    cx_reg <= CW'({1'b0, INV_GAIN});
                    cy_reg <= '0;
                    rot_reg <= 1'b1;
                    cnt_reg <= '0;
                    state_reg <= S_ROT1;
                end
                S_ROT1, S_VEC, S_ROT2:
                begin
                    if (pos)
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - at;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + at;
                    end
                    if (cordic_last)
                    begin
                        cnt_reg <= '0;
                        case (state_reg)
                            S_ROT1:
                            begin
                                c_reg <= pos ? cx_reg - ys : cx_reg + ys;
                                s_reg <= pos ? cy_reg + xs : cy_reg - xs;
                                if (len_sum == 17'd0)
                                begin
                                    beta_reg <= '0;
                                    dpsi_reg <= '0;
                                    state_reg <= S_ANG;
                                end
                                else
                                    state_reg <= S_MX;
                            end
                            S_VEC:
                            begin
                                beta_reg <= 32'(pos ? cz_reg - at : cz_reg + at);
                                state_reg <= S_MG;
                            end
                            default: state_reg <= S_PX;
                        endcase
                    end
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end
                S_MX:
                begin
                    prod_reg <= mp;
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    cx_reg <= CW'(prod_reg >>> 16);
                    prod_reg <= mp;
                    state_reg <= S_VINIT;
                end
                S_VINIT:
                begin
                    cy_reg <= CW'(prod_reg >>> 16);
                    cz_reg <= '0;
                    rot_reg <= 1'b0;
                    cnt_reg <= '0;
                    state_reg <= S_VEC;
                end
                S_MG:
                begin
                    prod_reg <= mp;
                    state_reg <= S_MS;
                end
                S_MS:
                begin
                    // Scaled magnitude; a non-positive value disables the heading update.
                    if (((prod_reg + (PW'(1) <<< 29)) >>> 30) > 0)
                        r_reg <= 32'((prod_reg + (PW'(1) <<< 29)) >>> 30);
                    else
                        r_reg <= '0;
                    prod_reg <= mp;
                    state_reg <= S_MA;
                end
                S_MA:
                begin
                    prod_reg <= mp;
                    state_reg <= S_MDEN;
                end
                S_MDEN:
                begin
                    num_reg <= prod_reg[NUM_W-1:0];
                    prod_reg <= mp;
                    state_reg <= S_DCHK;
                end
                S_DCHK:
                begin
                    den_reg <= prod_reg[DEN_W-1:0];
                    if (prod_reg[DEN_W-1:0] == '0)
                    begin
                        beta_reg <= '0;
                        dpsi_reg <= '0;
                        state_reg <= S_ANG;
                    end
                    else
                    begin
                        rem_reg <= '0;
                        q_reg <= '0;
                        dvd_reg <= {num_reg, 44'h0};
                        cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    dvd_reg <= dvd_reg << 1;
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= DEN_W'(rem_sh - {1'b0, den_reg});
                        q_reg <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[DEN_W-1:0];
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                    if (cnt_reg == 7'(DIV_BITS - 1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_ANG;
                    end
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end
                S_ANG:
                begin
                    // Quotient bits are final here when the divider ran.
                    if (den_reg != '0 && len_sum != 17'd0)
                        dpsi_reg <= s_reg[CW-1] ? 32'd0 - q_reg : q_reg;
                    den_reg <= '0;
                    flip_reg <= a_flip;
                    cx_reg <= CW'({1'b0, INV_GAIN});
                    cy_reg <= '0;
                    cz_reg <= CW'(a_f);
                    rot_reg <= 1'b1;
                    cnt_reg <= '0;
                    prod_reg <= mp;
                    state_reg <= S_ROT2;
                end
                S_PX:
                begin
                    vdt_reg <= prod_reg[31:0];
                    prod_reg <= mp;
                    state_reg <= S_PY;
                end
                S_PY:
                begin
                    px_reg <= sat_x;
                    prod_reg <= mp;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    py_reg <= sat_y;
                    ph_reg <= hd[31:16];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
